@@ hdl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Command codes, digit constants and segment tables for the display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // command codes
  localparam logic OP_RAW     = 1'b0;
  localparam logic OP_DECIMAL = 1'b1;

  // reciprocal constants for exact division of a 16-bit value
  localparam logic [15:0] RECIP_10   = 16'd52429;   // shift 19
  localparam logic [16:0] RECIP_100  = 17'd83887;   // shift 23
  localparam logic [16:0] RECIP_1000 = 17'd67109;   // shift 26

  typedef logic [3:0] digit_t;

  // outer position: P C D E in bits 15..12, G F A B in bits 3..0
  function automatic logic [15:0] outer_seg(input digit_t d);
    logic [15:0] seg;
    unique case (d)
      4'd0:    seg = 16'h7007;
      4'd1:    seg = 16'h4001;
      4'd2:    seg = 16'h300B;
      4'd3:    seg = 16'h600B;
      4'd4:    seg = 16'h400D;
      4'd5:    seg = 16'h600E;
      4'd6:    seg = 16'h700E;
      4'd7:    seg = 16'h4003;
      4'd8:    seg = 16'h700F;
      4'd9:    seg = 16'h600F;
      default: seg = 16'h0000;
    endcase
    return seg;
  endfunction

  // middle position: P C D E G F A B in bits 11..4
  function automatic logic [15:0] middle_seg(input digit_t d);
    logic [15:0] seg;
    unique case (d)
      4'd0:    seg = 16'h0770;
      4'd1:    seg = 16'h0410;
      4'd2:    seg = 16'h03B0;
      4'd3:    seg = 16'h06B0;
      4'd4:    seg = 16'h04D0;
      4'd5:    seg = 16'h06E0;
      4'd6:    seg = 16'h07E0;
      4'd7:    seg = 16'h0430;
      4'd8:    seg = 16'h07F0;
      4'd9:    seg = 16'h06F0;
      default: seg = 16'h0000;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

@@ hdl/seven_segment_serial_display_driver.sv @@
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Turns raw or decimal commands into a serial bit stream plus latch pulse
// for a chain of shift registers driving three seven-segment digits.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | operation (1b), payload (32b)
//  out     | out_valid/out_ready| serial_bit (1b), latch_pulse (1b)
//
//  each command yields SHIFT_LENGTH data-bit transactions, LSB first, then
//  one latch transaction: SHIFT_LENGTH + 1 transactions per command (33 by
//  default), from the single output shifter that emits one bit a cycle while out_ready is high.
//  a command waits in the hold register while the previous one shifts, so
//  the shifter reloads right after a latch with no gap.
//  an accepted command passes through the hold register into the shifter before its first bit goes out.
//  rst (synchronous) empties the hold register and stops the shifter.
//  an output stall freezes the shifter; the hold register still takes one
//  more command while the shifter is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_serial_display_driver
  import ssd_pkg::*;
#(
  parameter int SHIFT_LENGTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             serial_bit,
  output logic             latch_pulse
);

  localparam int CNT_W = $clog2(SHIFT_LENGTH + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SHIFT_LENGTH);

  // hold register: command plus quotients of the low 16 bits
  logic        hold_valid;
  logic        hold_op;
  logic [31:0] hold_payload;
  logic [12:0] hold_q10;
  logic [9:0]  hold_q100;
  logic [6:0]  hold_q1000;

  // shifter
  logic                    active;
  logic [SHIFT_LENGTH-1:0] shift_reg;
  logic [CNT_W-1:0]        count;

  // reciprocal products on the incoming value
  logic [31:0] prod10;
  logic [32:0] prod100;
  logic [32:0] prod1000;

  // digit extraction from the hold register
  logic [15:0] ones_full;
  logic [12:0] tens_full;
  logic [9:0]  hund_full;
  logic [31:0] seg_word;
  logic [31:0] load_word;

  logic out_take;
  logic is_latch;
  logic last_take;
  logic load;

  // ---- input side ----------------------------------------------------------

  assign prod10   = 32'(payload[15:0]) * 32'(RECIP_10);
  assign prod100  = 33'(payload[15:0]) * 33'(RECIP_100);
  assign prod1000 = 33'(payload[15:0]) * 33'(RECIP_1000);

  // hold register frees up in the same cycle the shifter loads from it
  assign in_ready = !hold_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op      <= operation;
      hold_payload <= payload;
      hold_q10     <= prod10[31:19];
      hold_q100    <= prod100[32:23];
      hold_q1000   <= prod1000[32:26];
    end
  end

  // ---- decimal decode ------------------------------------------------------

  // remainders by shift-add times ten: v - 10*(v/10) and so on
  assign ones_full = hold_payload[15:0]
                   - (({3'b000, hold_q10} << 3) + ({3'b000, hold_q10} << 1));
  assign tens_full = hold_q10
                   - ((13'(hold_q100) << 3) + (13'(hold_q100) << 1));
  assign hund_full = hold_q100
                   - ((10'(hold_q1000) << 3) + (10'(hold_q1000) << 1));

  // hundreds on the upper outer position, tens in the middle, ones below
  assign seg_word = {outer_seg(hund_full[3:0]), 16'h0000}
                  | {16'h0000, middle_seg(tens_full[3:0])}
                  | {16'h0000, outer_seg(ones_full[3:0])};

  assign load_word = (hold_op == OP_DECIMAL) ? seg_word : hold_payload;

  // ---- output shifter ------------------------------------------------------

  assign is_latch  = (count == LAST);
  assign out_take  = out_valid && out_ready;
  assign last_take = out_take && is_latch;
  assign load      = hold_valid && (!active || last_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (load) begin
      active <= 1'b1;
      count  <= '0;
    end else if (last_take) begin
      active <= 1'b0;
    end else if (out_take) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_reg <= load_word[SHIFT_LENGTH-1:0];
    end else if (out_take) begin
      shift_reg <= shift_reg >> 1;
    end
  end

  // data bits first, then the latch transaction with its data bit at zero
  assign out_valid   = active;
  assign serial_bit  = shift_reg[0] && !is_latch;
  assign latch_pulse = is_latch;

  // ---- assertions ----------------------------------------------------------

  // a waiting command starts shifting as soon as the shifter is idle
  a_idle_load : assert property (@(posedge clk) disable iff (rst)
    hold_valid && !active |=> active && count == '0)
    else $error("held command not loaded into idle shifter");

  // the bit counter never runs past the latch position
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    active |-> count <= LAST)
    else $error("shift counter out of range");

  // after a latch with a command waiting, the next command follows at once
  a_back_to_back : assert property (@(posedge clk) disable iff (rst)
    last_take && hold_valid |=> out_valid && !latch_pulse && count == '0)
    else $error("gap between consecutive commands");

  // a data bit transaction advances the counter by exactly one
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    out_take && !is_latch |=> count == $past(count) + CNT_W'(1))
    else $error("shift counter skipped");

endmodule

`default_nettype wire

@@ tb/segment_stream_checker.sv @@
// ----------------------------------------------------------------------------
// segment_stream_checker
// Watches both channels of the display driver, works out the 32-bit segment
// word for every accepted command and checks the serial bits and the latch
// result that come out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_stream_checker
  import ssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] payload,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        serial_bit,
  input  wire logic        latch_pulse,
  output int               mismatches,
  output int               results_due
);

  localparam int WORD_BITS = 32;

  typedef struct packed {
    logic data_bit;
    logic latch;
  } shift_slot_t;

  shift_slot_t pending_slots[$];
  int          results_seen;

  // outer digit position: P C D E in bits 15..12, G F A B in bits 3..0
  function automatic logic [15:0] outer_segments(input logic [3:0] digit);
    logic [15:0] seg;
    case (digit)
      4'd0:    seg = 16'h7007;
      4'd1:    seg = 16'h4001;
      4'd2:    seg = 16'h300B;
      4'd3:    seg = 16'h600B;
      4'd4:    seg = 16'h400D;
      4'd5:    seg = 16'h600E;
      4'd6:    seg = 16'h700E;
      4'd7:    seg = 16'h4003;
      4'd8:    seg = 16'h700F;
      default: seg = 16'h600F;
    endcase
    return seg;
  endfunction

  function automatic logic [31:0] display_word(input logic op, input logic [31:0] value);
    logic [15:0] number;
    logic [3:0]  hundreds;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [15:0] tens_outer;
    if (op == OP_RAW) return value;
    number   = value[15:0];
    hundreds = 4'((number / 100) % 10);
    tens     = 4'((number / 10) % 10);
    ones     = 4'(number % 10);
    // middle position holds the same segments packed into bits 11..4
    tens_outer = outer_segments(tens);
    return {outer_segments(hundreds), 16'h0000}
         | {20'h00000, tens_outer[15:12], tens_outer[3:0], 4'h0}
         | {16'h0000, outer_segments(ones)};
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    logic [31:0] word;
    shift_slot_t want;
    if (rst) begin
      pending_slots.delete();
      results_due  = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_slots.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected (bit %b, latch %b)",
                                    results_seen, serial_bit, latch_pulse));
        end else begin
          want = pending_slots.pop_front();
          if (serial_bit !== want.data_bit)
            report_mismatch($sformatf("result %0d serial_bit got %b expected %b",
                                      results_seen, serial_bit, want.data_bit));
          if (latch_pulse !== want.latch)
            report_mismatch($sformatf("result %0d latch_pulse got %b expected %b",
                                      results_seen, latch_pulse, want.latch));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        word = display_word(operation, payload);
        // lsb first, then the latch transaction with a zero data bit
        for (int i = 0; i < WORD_BITS; i++) pending_slots.push_back('{word[i], 1'b0});
        pending_slots.push_back('{1'b0, 1'b1});
      end
      results_due = pending_slots.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives raw and decimal commands into the seven-segment serial driver with
// random gaps and output stalls; the checker beside the block predicts and
// compares every serial transaction, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  localparam int RANDOM_COMMANDS = 400;
  localparam int IDLE_PERCENT    = 28;
  localparam int HOLD_AFTER      = 60;    // commands accepted before the long output stall
  localparam int HOLD_CYCLES     = 300;
  localparam int STEADY_FIRST    = 150;   // random commands with no idling on either side
  localparam int STEADY_LAST     = 230;
  localparam int PAUSE_AT        = 300;   // sender lets the block run dry here
  localparam int SETTLE_CYCLES   = 40;
  localparam int STALL_LIMIT     = 3000;  // cycles with no transaction on either channel

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [31:0] payload;
  logic        out_valid;
  logic        out_ready;
  logic        serial_bit;
  logic        latch_pulse;

  int mismatches;
  int results_due;
  int commands_sent;
  bit steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_serial_display_driver i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .serial_bit  (serial_bit),
    .latch_pulse (latch_pulse)
  );

  segment_stream_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .serial_bit  (serial_bit),
    .latch_pulse (latch_pulse),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // offer one command, with random idle cycles in front of it, and hold it
  // until the input transaction happens
  task automatic send_command(input logic op, input logic [31:0] value);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    payload   <= value;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
  endtask

  // stop offering and wait until every expected serial transaction is out;
  // the checker is read at the falling edge, after its update
  task automatic wait_for_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off that backs up the input side
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && commands_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk);
      end
    end
  end

  // ends the run if neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    logic        op;
    logic [31:0] value;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= OP_RAW;
    payload   <= '0;
    steady    = 1'b0;
    commands_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // raw words: extremes and alternating patterns
    send_command(OP_RAW, 32'h0000_0000);
    send_command(OP_RAW, 32'hFFFF_FFFF);
    send_command(OP_RAW, 32'hAAAA_AAAA);
    send_command(OP_RAW, 32'h5555_5555);
    send_command(OP_RAW, 32'h8000_0001);
    // decimal: every digit in the hundreds and ones positions, all but nine in the tens, digit eight everywhere
    send_command(OP_DECIMAL, 32'd0);
    send_command(OP_DECIMAL, 32'd123);
    send_command(OP_DECIMAL, 32'd234);
    send_command(OP_DECIMAL, 32'd345);
    send_command(OP_DECIMAL, 32'd456);
    send_command(OP_DECIMAL, 32'd567);
    send_command(OP_DECIMAL, 32'd678);
    send_command(OP_DECIMAL, 32'd789);
    send_command(OP_DECIMAL, 32'd888);
    send_command(OP_DECIMAL, 32'd901);
    send_command(OP_DECIMAL, 32'd12);
    // thousands dropped, upper payload half ignored, largest value
    send_command(OP_DECIMAL, 32'd1091);
    send_command(OP_DECIMAL, 32'd65535);
    send_command(OP_DECIMAL, 32'hFFFF_0008);
    send_command(OP_DECIMAL, 32'hDEAD_0159);

    // sender pause: the block runs completely empty
    wait_for_results();

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
      if (n == PAUSE_AT) wait_for_results();
      op = 1'($urandom_range(1));
      case ($urandom_range(2))
        0:       value = $urandom_range(999);
        1:       value = $urandom_range(65535);
        default: value = $urandom;
      endcase
      send_command(op, value);
    end
    steady = 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ssd_pkg.sv
hdl/seven_segment_serial_display_driver.sv
tb/segment_stream_checker.sv
tb/tb_top.sv
